FILE: rtl/mfbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbr_pkg: shared definitions for the MSB-first bit reader
// Sizes of the byte buffer and of the read window, item kinds and the
// control bundle that drives the shift and merge unit.
// ----------------------------------------------------------------------------
package mfbr_pkg;

	localparam int BUF_BYTES     = 1024;
	localparam int ADDR_W        = $clog2(BUF_BYTES);
	localparam int CNT_W         = ADDR_W + 1;
	localparam int MAX_READ_BITS = 32;
	localparam int BYTE_W        = 8;
	localparam int NUMB_W        = 6;
	localparam int AVAIL_W       = 14;
	localparam int WIN_BYTES     = (MAX_READ_BITS + 7 + BYTE_W - 1) / BYTE_W;
	localparam int WIN_W         = WIN_BYTES * BYTE_W;
	localparam int WCNT_W        = $clog2(WIN_BYTES + 1);
	localparam int SH_W          = $clog2(WIN_W);

	typedef enum logic [1:0] {
		KIND_CLEAR = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic clear;
		logic shift_en;
	} acc_ctrl_t;

endpackage

FILE: rtl/mfbr_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbr_mem: byte buffer memory
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module mfbr_mem (
	input  logic                          clk,
	input  logic                          wr_en,
	input  logic [mfbr_pkg::ADDR_W-1:0]   wr_addr,
	input  logic [mfbr_pkg::BYTE_W-1:0]   wr_data,
	input  logic                          rd_en,
	input  logic [mfbr_pkg::ADDR_W-1:0]   rd_addr,
	output logic [mfbr_pkg::BYTE_W-1:0]   rd_data
);
	import mfbr_pkg::*;

	logic [BYTE_W-1:0] mem_q [BUF_BYTES];
	logic [BYTE_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/mfbr_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfbr_accum: byte merge and bit extraction unit
// Collects the fetched bytes into a window one byte per cycle while shift_en
// is set, and cuts the requested bits out with a single right shift and mask.
// ----------------------------------------------------------------------------
module mfbr_accum (
	input  logic                          clk,
	input  mfbr_pkg::acc_ctrl_t           ctrl,
	input  logic [mfbr_pkg::BYTE_W-1:0]   byte_in,
	input  logic [mfbr_pkg::SH_W-1:0]     shift_amt,
	input  logic [mfbr_pkg::NUMB_W-1:0]   bit_len,
	output logic [mfbr_pkg::MAX_READ_BITS-1:0] bits_out
);
	import mfbr_pkg::*;

	logic [WIN_W-1:0]           win_q;
	logic [WIN_W-1:0]           shifted;
	logic [MAX_READ_BITS:0]     mask_wide;

	always_ff @(posedge clk) begin
		if (ctrl.clear) begin
			win_q <= '0;
		end else if (ctrl.shift_en) begin
			win_q <= {win_q[WIN_W-BYTE_W-1:0], byte_in};
		end
	end

	always_comb begin
		shifted   = win_q >> shift_amt;
		mask_wide = ((MAX_READ_BITS+1)'(1) << bit_len) - (MAX_READ_BITS+1)'(1);
		bits_out  = shifted[MAX_READ_BITS-1:0] & mask_wide[MAX_READ_BITS-1:0];
	end

endmodule

FILE: rtl/msb_first_bit_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msb_first_bit_reader: byte buffer read as an MSB-first bitstream
// Load items append bytes, read items return up to 32 bits, first bit most
// significant, and clear items empty the buffer. One result per item.
//
//   Channel  Handshake                    Payload
//   item     item_valid / item_ready      kind, byte_value, num_bits
//   result   result_valid / result_ready  value, error, available_bits
//
// A clear, a load, a rejected read or a zero-bit read at a byte boundary
// goes from IDLE to DONE. A read touching k bytes (k up to 5) runs FETCH,
// WAIT, DONE: the one-port buffer memory delivers one byte per cycle.
// Reset empties the buffer; no clearing pass is needed.
// A new item is taken only after the previous result has been loaded into
// the output register; a stalled result holds the block in its final state.
// ----------------------------------------------------------------------------
module msb_first_bit_reader (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  logic [1:0]                        kind,
	input  logic [7:0]                        byte_value,
	input  logic [5:0]                        num_bits,
	output logic                              result_valid,
	input  logic                              result_ready,
	output logic [31:0]                       value,
	output logic                              error,
	output logic [13:0]                       available_bits
);
	import mfbr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_WAIT,
		ST_DONE
	} state_t;

	state_t                  state_q;
	logic [CNT_W-1:0]        byte_count_q;
	logic [CNT_W-1:0]        byte_pos_q;
	logic [2:0]              bit_pos_q;
	logic [AVAIL_W-1:0]      avail_q;
	logic [ADDR_W-1:0]       base_q;
	logic [WCNT_W-1:0]       nbytes_q;
	logic [WCNT_W-1:0]       fetch_cnt_q;
	logic [SH_W-1:0]         shift_q;
	logic [NUMB_W-1:0]       len_q;
	logic                    err_q;
	logic                    rd_valid_s1;
	logic                    result_valid_q;
	logic [MAX_READ_BITS-1:0] value_q;
	logic                    error_q;
	logic [AVAIL_W-1:0]      avail_out_q;

	logic                    take;
	kind_t                   kind_in;
	logic                    load_ok;
	logic                    read_ok;
	logic                    read_bad;
	logic [NUMB_W-1:0]       end_bits;
	logic [NUMB_W-1:0]       need_sum;
	logic [WCNT_W-1:0]       need_bytes;
	logic [SH_W-1:0]         need_shift;
	logic                    rd_en;
	logic [ADDR_W-1:0]       rd_addr;
	logic [BYTE_W-1:0]       rd_data;
	acc_ctrl_t               acc_ctrl;
	logic [MAX_READ_BITS-1:0] bits_out;
	logic                    out_free;

	assign item_ready = (state_q == ST_IDLE);
	assign take       = item_valid && item_ready;
	assign kind_in    = kind_t'(kind);
	assign out_free   = !result_valid_q || result_ready;

	always_comb begin
		load_ok    = (byte_count_q < CNT_W'(BUF_BYTES));
		read_bad   = (num_bits > NUMB_W'(MAX_READ_BITS)) ||
			(AVAIL_W'(num_bits) > avail_q);
		read_ok    = !read_bad;
		end_bits   = NUMB_W'(bit_pos_q) + num_bits;
		need_sum   = end_bits + NUMB_W'(BYTE_W - 1);
		need_bytes = WCNT_W'(need_sum >> 3);
		need_shift = SH_W'((NUMB_W+1)'(need_bytes) * (NUMB_W+1)'(BYTE_W)
			- (NUMB_W+1)'(end_bits));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			byte_pos_q   <= '0;
			bit_pos_q    <= '0;
			avail_q      <= '0;
		end else if (take) begin
			case (kind_in)
				KIND_CLEAR: begin
					byte_count_q <= '0;
					byte_pos_q   <= '0;
					bit_pos_q    <= '0;
					avail_q      <= '0;
				end
				KIND_LOAD: begin
					if (load_ok) begin
						byte_count_q <= byte_count_q + CNT_W'(1);
						avail_q      <= avail_q + AVAIL_W'(BYTE_W);
					end
				end
				KIND_READ: begin
					if (read_ok) begin
						bit_pos_q  <= end_bits[2:0];
						byte_pos_q <= byte_pos_q + CNT_W'(end_bits >> 3);
						avail_q    <= avail_q - AVAIL_W'(num_bits);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			base_q   <= byte_pos_q[ADDR_W-1:0];
			shift_q  <= need_shift;
			nbytes_q <= need_bytes;
			if (kind_in == KIND_READ && read_ok) begin
				len_q <= num_bits;
			end else begin
				len_q <= '0;
			end
			err_q <= (kind_in == KIND_LOAD && !load_ok) ||
				(kind_in == KIND_READ && read_bad);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			fetch_cnt_q    <= '0;
			rd_valid_s1    <= 1'b0;
			result_valid_q <= 1'b0;
			value_q        <= '0;
			error_q        <= 1'b0;
			avail_out_q    <= '0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (result_valid_q && result_ready && state_q != ST_DONE) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					fetch_cnt_q <= '0;
					if (take) begin
						if (kind_in == KIND_READ && read_ok && need_bytes != '0) begin
							state_q <= ST_FETCH;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_FETCH: begin
					fetch_cnt_q <= fetch_cnt_q + WCNT_W'(1);
					if (fetch_cnt_q + WCNT_W'(1) == nbytes_q) begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						value_q        <= bits_out;
						error_q        <= err_q;
						avail_out_q    <= avail_q;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rd_en   = (state_q == ST_FETCH);
	assign rd_addr = base_q + ADDR_W'(fetch_cnt_q);

	always_comb begin
		acc_ctrl.clear    = take;
		acc_ctrl.shift_en = rd_valid_s1;
	end

	mfbr_mem u_mem (
		.clk     (clk),
		.wr_en   (take && kind_in == KIND_LOAD && load_ok),
		.wr_addr (byte_count_q[ADDR_W-1:0]),
		.wr_data (byte_value),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mfbr_accum u_accum (
		.clk       (clk),
		.ctrl      (acc_ctrl),
		.byte_in   (rd_data),
		.shift_amt (shift_q),
		.bit_len   (len_q),
		.bits_out  (bits_out)
	);

	assign result_valid   = result_valid_q;
	assign value          = value_q;
	assign error          = error_q;
	assign available_bits = avail_out_q;

	// The bit counter must always agree with the byte and bit positions.
	a_avail_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		avail_q == AVAIL_W'(BYTE_W) * AVAIL_W'(byte_count_q - byte_pos_q)
			- AVAIL_W'(bit_pos_q))
		else $error("available bit count out of step with positions");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_pos_q <= byte_count_q && byte_count_q <= CNT_W'(BUF_BYTES))
		else $error("read position beyond loaded bytes");

	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FETCH |-> fetch_cnt_q < nbytes_q &&
			AVAIL_W'(base_q) + AVAIL_W'(fetch_cnt_q) < AVAIL_W'(byte_count_q))
		else $error("fetch past the loaded bytes");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && out_free |=> !error_q || value_q == '0)
		else $error("rejected item returned data");

endmodule

FILE: tb/sv/tb_msb_first_bit_reader.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_msb_first_bit_reader: self-checking bench for the MSB-first bit reader
// Each accepted item updates a behavioural copy of the byte buffer and its
// read pointers. That copy yields the value, error flag and remaining bit
// count the block must return. Directed corner cases come first, then a fill
// of the whole buffer, then random load and read streams with some noise.
// Both channels idle at random, except for one long stretch with no gaps.
// ----------------------------------------------------------------------------
module tb_msb_first_bit_reader;
	import mfbr_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int STREAM_ITEMS = 260;

	typedef struct {
		logic [31:0]        value;
		logic               error;
		logic [AVAIL_W-1:0] avail;
	} read_result_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_ready;
	logic [1:0]         kind;
	logic [7:0]         byte_value;
	logic [5:0]         num_bits;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic [31:0]        value;
	logic               error;
	logic [AVAIL_W-1:0] available_bits;

	logic [7:0]   buffered_bytes [BUF_BYTES];
	int           fill_count;
	int           byte_ptr;
	int           bit_ptr;
	read_result_t pending_results [$];

	bit          no_idle;
	int unsigned items_sent;
	int unsigned mismatch_count;
	int unsigned cycle_count;
	int unsigned kind_tally [4];
	int unsigned flagged_count;
	int unsigned bits_delivered;

	msb_first_bit_reader DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.kind           (kind),
		.byte_value     (byte_value),
		.num_bits       (num_bits),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.value          (value),
		.error          (error),
		.available_bits (available_bits)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Run stopped after %0d cycles with %0d results outstanding.",
				cycle_count, pending_results.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk)
		result_ready <= no_idle || ($urandom_range(99) >= 16);

	function automatic int bits_left();
		return 8 * (fill_count - byte_ptr) - bit_ptr;
	endfunction

	// Applies one transfer to the buffer copy and queues the result it implies.
	task automatic predict_reader_result(kind_t k, logic [7:0] b, logic [5:0] n);
		read_result_t r;
		int           i;
		r.value = '0;
		r.error = 1'b0;
		kind_tally[k]++;
		case (k)
			KIND_CLEAR: begin
				fill_count = 0;
				byte_ptr   = 0;
				bit_ptr    = 0;
			end
			KIND_LOAD: begin
				if (fill_count >= BUF_BYTES) begin
					r.error = 1'b1;
				end else begin
					buffered_bytes[fill_count] = b;
					fill_count++;
				end
			end
			KIND_READ: begin
				if (n > MAX_READ_BITS || n > bits_left()) begin
					r.error = 1'b1;
				end else begin
					for (i = 0; i < n; i++) begin
						r.value = {r.value[30:0], buffered_bytes[byte_ptr][7 - bit_ptr]};
						bit_ptr++;
						if (bit_ptr == 8) begin
							bit_ptr = 0;
							byte_ptr++;
						end
					end
					bits_delivered += n;
				end
			end
			default: ;
		endcase
		if (r.error)
			flagged_count++;
		r.avail = AVAIL_W'(bits_left());
		pending_results.push_back(r);
	endtask

	// Called at a rising edge; returns at the edge on which the item transfers.
	task automatic send_item(kind_t k, logic [7:0] b, logic [5:0] n);
		while (!no_idle && $urandom_range(99) < 16) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		kind       <= k;
		byte_value <= b;
		num_bits   <= n;
		@(negedge clk);
		while (!item_ready)
			@(negedge clk);
		@(posedge clk);
		predict_reader_result(k, b, n);
		if (k != KIND_NONE)
			items_sent++;
	endtask

	task automatic report_mismatch(string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	always @(negedge clk) begin
		read_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result value=%h error=%b avail=%0d",
					value, error, available_bits));
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value)
					report_mismatch($sformatf("value %h, expected %h", value, want.value));
				if (error !== want.error)
					report_mismatch($sformatf("error %b, expected %b", error, want.error));
				if (available_bits !== want.avail)
					report_mismatch($sformatf("available_bits %0d, expected %0d",
						available_bits, want.avail));
			end
		end
	end

	task automatic test_directed_cases();
		send_item(KIND_READ, 8'h00, 6'd0);
		send_item(KIND_READ, 8'hFF, 6'd1);
		send_item(KIND_NONE, 8'hFF, 6'd63);
		send_item(KIND_LOAD, 8'hFF, 6'd0);
		send_item(KIND_LOAD, 8'h00, 6'd63);
		send_item(KIND_LOAD, 8'hA5, 6'd0);
		send_item(KIND_LOAD, 8'h3C, 6'd0);
		send_item(KIND_LOAD, 8'h81, 6'd0);
		send_item(KIND_READ, 8'h00, 6'd33);
		send_item(KIND_READ, 8'h00, 6'd63);
		send_item(KIND_READ, 8'h00, 6'd1);
		send_item(KIND_READ, 8'h00, 6'd2);
		send_item(KIND_READ, 8'h00, 6'd0);
		send_item(KIND_READ, 8'h00, 6'd32);
		send_item(KIND_READ, 8'h00, 6'd6);
		send_item(KIND_READ, 8'h00, 6'd5);
		send_item(KIND_READ, 8'h00, 6'd1);
		send_item(KIND_NONE, 8'h00, 6'd0);
		send_item(KIND_LOAD, 8'h5A, 6'd0);
		send_item(KIND_CLEAR, 8'hFF, 6'd63);
		send_item(KIND_READ, 8'h00, 6'd8);
		send_item(KIND_LOAD, 8'hFF, 6'd0);
		send_item(KIND_READ, 8'h00, 6'd8);
	endtask

	// Fills every entry, then pushes past capacity; runs without idle cycles.
	task automatic test_fill_to_capacity();
		int i;
		no_idle = 1'b1;
		send_item(KIND_CLEAR, 8'h00, 6'd0);
		for (i = 0; i < BUF_BYTES; i++)
			send_item(KIND_LOAD, 8'($urandom_range(255)), 6'($urandom_range(63)));
		send_item(KIND_LOAD, 8'hFF, 6'd0);
		send_item(KIND_LOAD, 8'h00, 6'd0);
		send_item(KIND_READ, 8'h00, 6'd33);
		for (i = 0; i < 80; i++)
			send_item(KIND_READ, 8'($urandom_range(255)), 6'($urandom_range(32)));
		send_item(KIND_CLEAR, 8'h00, 6'd0);
		no_idle = 1'b0;
	endtask

	task automatic test_random_streams();
		int unsigned first_item;
		int          i;
		int          n_loads;
		int          n_reads;
		int          left;
		int unsigned pick;
		first_item = items_sent;
		while (items_sent - first_item < STREAM_ITEMS) begin
			if ($urandom_range(9) == 0)
				send_item(KIND_CLEAR, 8'($urandom_range(255)), 6'($urandom_range(63)));
			n_loads = $urandom_range(1, 12);
			for (i = 0; i < n_loads; i++)
				send_item(KIND_LOAD, 8'($urandom_range(255)), 6'($urandom_range(63)));
			n_reads = $urandom_range(1, 10);
			for (i = 0; i < n_reads; i++) begin
				left = bits_left();
				pick = $urandom_range(99);
				if (pick < 80)
					send_item(KIND_READ, 8'($urandom_range(255)),
						6'($urandom_range(0, left < MAX_READ_BITS ? left : MAX_READ_BITS)));
				else if (pick < 92)
					send_item(KIND_READ, 8'($urandom_range(255)), 6'($urandom_range(63)));
				else if (pick < 96)
					send_item(KIND_NONE, 8'($urandom_range(255)), 6'($urandom_range(63)));
				else
					send_item(KIND_READ, 8'($urandom_range(255)),
						6'(left < MAX_READ_BITS ? left + 1 : MAX_READ_BITS + 1));
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		kind       = KIND_CLEAR;
		byte_value = '0;
		num_bits   = '0;
		no_idle    = 1'b0;
		fill_count = 0;
		byte_ptr   = 0;
		bit_ptr    = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_fill_to_capacity();
		test_random_streams();

		item_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Transfers: %0d clears, %0d loads, %0d reads, %0d unused kind; %0d flagged.",
			kind_tally[KIND_CLEAR], kind_tally[KIND_LOAD], kind_tally[KIND_READ],
			kind_tally[KIND_NONE], flagged_count);
		$display("%0d bits were read back; %0d mismatches were found.",
			bits_delivered, mismatch_count);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
rtl/mfbr_pkg.sv
rtl/mfbr_mem.sv
rtl/mfbr_accum.sv
rtl/msb_first_bit_reader.sv
tb/sv/tb_msb_first_bit_reader.sv
